// ===== hdl/kmde_pkg.sv =====
// Shared types, constants and mask functions for the keypad matrix debounce block.
// Used by kmde_ctrl, kmde_datapath and keypad_matrix_debounce_events_top.
package kmde_pkg;

	localparam int ROWS    = 8;
	localparam int COLUMNS = 8;

	localparam int KEYS       = 64;
	localparam int IDX_W      = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int CNT_W      = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_ROW_MASK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_MASK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STABLE   = 2'd2;

	localparam logic [CNT_W-1:0] STABLE_SCANS_RST = 4'd3;
	localparam logic [CNT_W-1:0] CNT_MAX          = 4'd15;

	localparam logic [7:0] ROW_LIMIT = 8'((16'd1 << ROWS) - 16'd1);

	typedef struct packed {
		logic load;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic diff_empty;
		logic bit_set;
		logic out_free;
	} sts_t;

	function automatic logic [KEYS-1:0] enabled_keys(input logic [7:0] row_mask,
	                                                  input logic [7:0] col_mask);
		logic [KEYS-1:0] m;
		m = '0;
		for (int c = 0; c < COLUMNS; c++) begin
			if (col_mask[c]) begin
				m[c*8 +: 8] = row_mask & ROW_LIMIT;
			end
		end
		return m;
	endfunction

	function automatic logic [KEYS-1:0] enabled_cols(input logic [7:0] col_mask);
		logic [KEYS-1:0] m;
		m = '0;
		for (int c = 0; c < COLUMNS; c++) begin
			if (col_mask[c]) begin
				m[c*8 +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage

// ===== hdl/keypad_matrix_debounce_events_top.sv =====
// Keypad matrix debounce and key change event generator, top level.
// Depends on kmde_pkg, kmde_ctrl and kmde_datapath.
//
// Usage:
//   Input stream: one beat per full matrix scan; s_tdata bit col*8+row is 1
//   when that contact is closed. Output stream: one beat per changed enabled
//   key, ascending column then row; m_tlast marks the final beat of a scan.
//   Configuration: cfg_wr_en with cfg_index 0 (row mask), 1 (column mask),
//   2 (stable scan count, 4 bits); write only while the block is idle.
// Timing:
//   A scan is taken while the block is idle; the change bits are then walked
//   one key position per cycle unless a receiver stall holds the walk, and
//   the next scan is accepted once the walk has passed the highest changed
//   key position, or once the walk finds no change bit when the scan
//   releases no event.
// Reset: masks clear to zero, stable count to 3, both snapshots and the
//   counter to zero; no beat is pending.
// Stall: with m_tready low and an event pending, the walk stops at the next
//   changed key; the pending event stays in the output register and nothing is dropped.
module keypad_matrix_debounce_events_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [kmde_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kmde_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [kmde_pkg::KEYS-1:0]        s_tdata,   // [63:0] scan_matrix
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [7:0]                        m_tdata,   // [2:0] key_row, [5:3] key_column,
	                                                     // [6] pressed, [7] zero
	output logic                              m_tlast    // last_event
);

	kmde_pkg::cmd_t cmd;
	kmde_pkg::sts_t sts;

	kmde_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	kmde_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== hdl/kmde_ctrl.sv =====
// Controller for the keypad debounce block: idle/walk state machine.
// Depends on kmde_pkg for command and status structs.
module kmde_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  kmde_pkg::sts_t sts,
	output kmde_pkg::cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	state_t state_q;
	logic   ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && ready_q) begin
						state_q <= ST_WALK;
						ready_q <= 1'b0;
					end
				end
				ST_WALK: begin
					if (sts.diff_empty) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign s_tready = ready_q;
	assign cmd.load = s_tvalid && ready_q;
	assign cmd.step = (state_q == ST_WALK) && !sts.diff_empty
	                  && (!sts.bit_set || sts.out_free);

endmodule

// ===== hdl/kmde_datapath.sv =====
// Datapath for the keypad debounce block: config registers, debounce state,
// change-bit walker and event output register. Depends on kmde_pkg.
module kmde_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [kmde_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kmde_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic [kmde_pkg::KEYS-1:0]        s_tdata,
	input  kmde_pkg::cmd_t                    cmd,
	output kmde_pkg::sts_t                    sts,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [7:0]                        m_tdata,
	output logic                              m_tlast
);

	logic [7:0]                      row_mask_q;
	logic [7:0]                      col_mask_q;
	logic [kmde_pkg::CNT_W-1:0]      stable_scans_q;

	logic [kmde_pkg::KEYS-1:0]       unstable_q;
	logic [kmde_pkg::KEYS-1:0]       stable_q;
	logic [kmde_pkg::CNT_W-1:0]      cnt_q;
	logic [kmde_pkg::KEYS-1:0]       diff_q;
	logic [kmde_pkg::KEYS-1:0]       vol_shift_q;
	logic [kmde_pkg::IDX_W-1:0]      idx_q;

	logic                            out_valid_q;
	logic [2:0]                      out_row_q;
	logic [2:0]                      out_col_q;
	logic                            out_pressed_q;
	logic                            out_last_q;

	logic [kmde_pkg::KEYS-1:0]       keys;
	logic [kmde_pkg::KEYS-1:0]       cols;
	logic [kmde_pkg::KEYS-1:0]       vol;
	logic                            changed;
	logic [kmde_pkg::CNT_W-1:0]      cnt_next;
	logic                            fire;
	logic                            emit;
	logic                            out_free;

	assign keys     = kmde_pkg::enabled_keys(row_mask_q, col_mask_q);
	assign cols     = kmde_pkg::enabled_cols(col_mask_q);
	assign vol      = s_tdata & keys;
	assign changed  = |((unstable_q ^ vol) & cols);
	assign cnt_next = changed ? '0 :
	                  (cnt_q != kmde_pkg::CNT_MAX) ? cnt_q + 4'd1 : cnt_q;
	assign fire     = (cnt_next == stable_scans_q);
	assign out_free = !out_valid_q || m_tready;
	assign emit     = cmd.step && diff_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_mask_q     <= '0;
			col_mask_q     <= '0;
			stable_scans_q <= kmde_pkg::STABLE_SCANS_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				kmde_pkg::CFG_ROW_MASK: row_mask_q     <= cfg_wdata;
				kmde_pkg::CFG_COL_MASK: col_mask_q     <= cfg_wdata;
				kmde_pkg::CFG_STABLE:   stable_scans_q <= cfg_wdata[kmde_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unstable_q  <= '0;
			stable_q    <= '0;
			cnt_q       <= '0;
			diff_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q <= cnt_next;
				if (changed) begin
					unstable_q <= vol;
				end
				if (fire) begin
					stable_q <= vol;
					diff_q   <= (stable_q ^ vol) & keys;
				end else begin
					diff_q   <= '0;
				end
			end else if (cmd.step) begin
				diff_q <= diff_q >> 1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			vol_shift_q <= vol;
			idx_q       <= '0;
		end else if (cmd.step) begin
			vol_shift_q <= vol_shift_q >> 1;
			idx_q       <= idx_q + 6'd1;
		end
		if (emit) begin
			out_row_q     <= idx_q[2:0];
			out_col_q     <= idx_q[5:3];
			out_pressed_q <= vol_shift_q[0];
			out_last_q    <= ~|diff_q[kmde_pkg::KEYS-1:1];
		end
	end

	assign sts.diff_empty = ~|diff_q;
	assign sts.bit_set    = diff_q[0];
	assign sts.out_free   = out_free;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_pressed_q, out_col_q, out_row_q};
	assign m_tlast  = out_last_q;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for keypad_matrix_debounce_events_top: scans in, key change beats out.
// Depends on kmde_pkg and the RTL under hdl/; a scoreboard class predicts debounce and events.
// Directed extremes first, then random bouncing and settling scan sequences under several settings.

typedef struct packed {
	logic [2:0] row;
	logic [2:0] column;
	logic       pressed;
	logic       last;
} key_event_t;

class key_event_board;
	logic [7:0]  row_mask;
	logic [7:0]  col_mask;
	logic [3:0]  stable_need;
	logic [63:0] snapshot;
	logic [63:0] settled;
	logic [3:0]  settle_count;
	key_event_t  due_events[$];
	int          fails;
	int          scans;
	int          presses;
	int          releases;

	function new();
		row_mask     = 8'h00;
		col_mask     = 8'h00;
		stable_need  = kmde_pkg::STABLE_SCANS_RST;
		snapshot     = '0;
		settled      = '0;
		settle_count = '0;
		fails        = 0;
		scans        = 0;
		presses      = 0;
		releases     = 0;
	endfunction

	function void write_reg(input logic [kmde_pkg::CFG_IDX_W-1:0] index,
	                        input logic [kmde_pkg::CFG_DATA_W-1:0] value);
		case (index)
			kmde_pkg::CFG_ROW_MASK: row_mask = value;
			kmde_pkg::CFG_COL_MASK: col_mask = value;
			kmde_pkg::CFG_STABLE:   stable_need = value[3:0];
			default: ;
		endcase
	endfunction

	function int outstanding();
		return due_events.size();
	endfunction

	// Debounce one accepted scan and queue the change beats it releases.
	function void take_scan(input logic [63:0] scan);
		logic [63:0] key_on;
		logic [63:0] col_on;
		logic [63:0] live;
		logic [63:0] changed;
		key_event_t  ev;
		int          total;
		int          n;
		key_on = '0;
		col_on = '0;
		for (int c = 0; c < 8; c++) begin
			for (int r = 0; r < 8; r++) begin
				if (c < kmde_pkg::COLUMNS && col_mask[c]) begin
					col_on[c*8+r] = 1'b1;
					if (r < kmde_pkg::ROWS && row_mask[r])
						key_on[c*8+r] = 1'b1;
				end
			end
		end
		scans++;
		live = scan & key_on;
		if (((snapshot ^ live) & col_on) != '0) begin
			snapshot     = live;
			settle_count = '0;
		end else if (settle_count != kmde_pkg::CNT_MAX) begin
			settle_count++;
		end
		if (settle_count == stable_need) begin
			changed = (settled ^ live) & key_on;
			total   = $countones(changed);
			n       = 0;
			for (int k = 0; k < 64; k++) begin
				if (changed[k]) begin
					n++;
					ev.row     = 3'(k % 8);
					ev.column  = 3'(k / 8);
					ev.pressed = live[k];
					ev.last    = (n == total);
					due_events.push_back(ev);
				end
			end
			settled = live;
		end
	endfunction

	function void match_event(input logic [7:0] beat, input logic last);
		key_event_t ev;
		logic [7:0] want;
		if (due_events.size() == 0) begin
			fails++;
			if (fails <= 20)
				$display("%0t: unexpected beat, expected none, got tdata %h tlast %b",
				         $time, beat, last);
			return;
		end
		ev   = due_events.pop_front();
		want = {1'b0, ev.pressed, ev.column, ev.row};
		if (beat !== want || last !== ev.last) begin
			fails++;
			if (fails <= 20)
				$display("%0t: mismatch, expected tdata %h tlast %b, got tdata %h tlast %b",
				         $time, want, ev.last, beat, last);
		end
		if (ev.pressed)
			presses++;
		else
			releases++;
	endfunction
endclass

module testbench;

	localparam int CYCLE_LIMIT = 2000000;

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               cfg_wr_en;
	logic [kmde_pkg::CFG_IDX_W-1:0]     cfg_index;
	logic [kmde_pkg::CFG_DATA_W-1:0]    cfg_wdata;
	logic                               s_tvalid;
	logic                               s_tready;
	logic [kmde_pkg::KEYS-1:0]          s_tdata;
	logic                               m_tvalid;
	logic                               m_tready;
	logic [7:0]                         m_tdata;
	logic                               m_tlast;

	key_event_board board = new();
	int tx_gap_odds   = 0;
	int rx_stall_odds = 0;
	int settings_used = 0;
	int cycle_count   = 0;

	keypad_matrix_debounce_events_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.match_event(m_tdata, m_tlast);
	end

	initial begin
		int stall_left;
		stall_left = 0;
		m_tready   = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (rx_stall_odds != 0 && $urandom_range(0, rx_stall_odds * 4) == 0) begin
				stall_left = $urandom_range(0, 17);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles", cycle_count);
		$display("Some tests failed");
		$finish;
	end

	task automatic send_scan(input logic [63:0] scan);
		if (tx_gap_odds != 0 && $urandom_range(0, tx_gap_odds) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= scan;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.take_scan(scan);
	endtask

	// Drain all due beats, then let a walk with no output finish.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic put_reg(input logic [kmde_pkg::CFG_IDX_W-1:0] index,
	                       input logic [kmde_pkg::CFG_DATA_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(posedge clk);
		board.write_reg(index, value);
	endtask

	task automatic set_config(input logic [7:0] rows, input logic [7:0] cols,
	                          input logic [3:0] need);
		wait_idle();
		put_reg(kmde_pkg::CFG_ROW_MASK, rows);
		put_reg(kmde_pkg::CFG_COL_MASK, cols);
		put_reg(kmde_pkg::CFG_STABLE, {4'd0, need});
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [63:0] pick_scan(input logic [63:0] prev);
		logic [63:0] scan;
		case ($urandom_range(0, 5))
			0, 1: scan = {$urandom, $urandom};
			2, 3: scan = prev ^ (64'd1 << $urandom_range(0, 63))
			             ^ (64'd1 << $urandom_range(0, 63));
			4:    scan = ~prev;
			default: scan = $urandom_range(0, 1) ? '1 : '0;
		endcase
		return scan;
	endfunction

	// Mostly settle on a target after some bounce; the rest is single noise scans.
	task automatic run_phase(input int budget);
		logic [63:0] target;
		int sent;
		int reps;
		target = '0;
		sent   = 0;
		while (sent < budget) begin
			target = pick_scan(target);
			if ($urandom_range(0, 9) < 7) begin
				repeat ($urandom_range(0, 2)) begin
					send_scan(pick_scan(target));
					sent++;
				end
				reps = int'(board.stable_need) + 1 + $urandom_range(0, 2);
				repeat (reps) begin
					send_scan(target);
					sent++;
				end
			end else begin
				send_scan(target);
				sent++;
			end
		end
	endtask

	initial begin
		logic [63:0] pattern;
		logic [7:0]  rows;
		logic [7:0]  cols;
		arst_n    = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset masks disable every key
		send_scan('1);

		set_config(8'hFF, 8'hFF, 4'd1);
		send_scan('1);
		send_scan('1);
		send_scan('0);
		send_scan('0);

		set_config(8'hFF, 8'hFF, 4'd0);
		send_scan(64'h8000_0000_0000_0001);

		set_config(8'h0F, 8'hF0, 4'd15);
		pattern = {$urandom, $urandom};
		repeat (17) send_scan(pattern);

		for (int p = 0; p < 9; p++) begin
			tx_gap_odds   = (p == 8) ? 0 : $urandom_range(0, 3);
			rx_stall_odds = (p == 8) ? 0 : $urandom_range(0, 3);
			rows = 8'($urandom | $urandom);
			cols = 8'($urandom | $urandom);
			case (p)
				0: set_config(8'hFF, 8'hFF, 4'd1);
				1: set_config(8'hFF, 8'hFF, 4'd14);
				2: set_config(8'h00, 8'hFF, 4'd2);
				3: set_config(8'hFF, 8'h00, 4'd2);
				4: set_config(8'h81, 8'h81, 4'd15);
				5: set_config(rows, cols, 4'd0);
				8: set_config(8'hFF, 8'hFF, 4'($urandom_range(1, 4)));
				default: set_config(rows, cols, 4'($urandom_range(0, 15)));
			endcase
			run_phase((p == 2 || p == 3) ? 8 : 40);
		end

		wait_idle();
		$display("Ran %0d scans under %0d register settings with random gaps and stalls,",
		         board.scans, settings_used);
		$display("checking %0d press and %0d release beats.", board.presses, board.releases);
		if (board.fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
